// ===== src/smstep_pkg.sv =====
// package for the stack machine execution core
// opcode, trap codes and shared command/status types; no dependencies
`timescale 1ns / 1ps

package smstep_pkg;

	localparam int DefStackDepth   = 128;
	localparam int DefProgramDepth = 128;
	localparam int DefDataWidth    = 32;
	localparam int OpWidth         = 4;
	localparam int OperandWidth    = 32;
	localparam int TrapWidth       = 3;
	localparam int PcWidth         = 7;
	localparam int DepthWidth      = 8;
	localparam int TopWidth        = 32;

	typedef enum logic [OpWidth-1:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MUL   = 4'd5,
		OP_HALT  = 4'd6,
		OP_JMP   = 4'd7,
		OP_EQ    = 4'd8,
		OP_GT    = 4'd9,
		OP_LT    = 4'd10,
		OP_JMPIF = 4'd11
	} opcode_t;

	typedef enum logic [TrapWidth-1:0] {
		TRAP_OK        = 3'd0,
		TRAP_OVERFLOW  = 3'd1,
		TRAP_UNDERFLOW = 3'd2,
		TRAP_BAD_OP    = 3'd3,
		TRAP_BAD_ADDR  = 3'd4,
		TRAP_DIV_ZERO  = 3'd5
	} trap_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture instruction, start stack reads
		logic exec;      // evaluate and commit (not for div)
		logic div_start; // launch divider
		logic div_commit;// commit divider result
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_needed; // instruction is a legal divide
		logic div_done;
	} dp_stat_t;

endpackage

// ===== src/smstep_if.sv =====
// valid/ready stream interface with a typed payload
// depends on nothing
`timescale 1ns / 1ps

interface smstep_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/stack_machine_step.sv =====
// top level of the stack machine execution core
// depends on smstep_pkg, smstep_if, smstep_ctrl, smstep_dp, smstep_div
`timescale 1ns / 1ps
//
// usage:
//  - instr (sink): one transaction per instruction, fields opcode and operand,
//    taken at the current program counter by an outside fetcher
//  - result (source): one transaction per instruction with trap, next_pc,
//    halted, stack_depth and top_value
//  - cfg_we / cfg_data write program_length while the core is idle
//  an instruction is loaded with the stack read, then executed and committed; a
//  divide instead runs through the one-bit-per-cycle divider before it commits
//  a new instruction is taken only in idle, once the previous one has committed;
//  the stack read and read-modify-write use the single stack memory
//  reset clears depth, program counter, halt flag and program_length; stack
//  contents are undefined until pushed
//  a stalled result holds in the output register; the next instruction is
//  accepted in the cycle the result is taken
//
module stack_machine_step #(
	parameter int STACK_DEPTH   = smstep_pkg::DefStackDepth,
	parameter int PROGRAM_DEPTH = smstep_pkg::DefProgramDepth,
	parameter int DATA_WIDTH    = smstep_pkg::DefDataWidth
) (
	input  logic clk,
	input  logic arst_n,
	smstep_if.sink   instr,
	smstep_if.source result,
	input  logic                           cfg_we,
	input  logic [smstep_pkg::PcWidth-1:0] cfg_data
);
	logic [smstep_pkg::PcWidth-1:0] plen_q;
	smstep_pkg::dp_cmd_t  cmd;
	smstep_pkg::dp_stat_t stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= '0;
		else if (cfg_we) plen_q <= cfg_data;
	end

	smstep_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(instr.valid), .in_ready(instr.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.cmd(cmd), .stat(stat)
	);

	smstep_dp #(
		.STACK_DEPTH(STACK_DEPTH), .PROGRAM_DEPTH(PROGRAM_DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.program_length(plen_q),
		.opcode(instr.payload.opcode), .operand(instr.payload.operand),
		.trap(result.payload.trap), .next_pc(result.payload.next_pc),
		.halted(result.payload.halted), .stack_depth(result.payload.stack_depth),
		.top_value(result.payload.top_value)
	);
endmodule

// ===== src/smstep_div.sv =====
// iterative signed divider, one quotient bit per cycle
// depends on nothing; stand-alone unit
`timescale 1ns / 1ps

module smstep_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient
);
	localparam int CntWidth = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] rem_q, quo_q, dvs_q;
	logic [CntWidth-1:0]   cnt_q;
	logic                  busy_q, neg_q, done_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   shifted;

	// restoring step
	assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes in, quotient bits shifted in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_WIDTH-1] ? -dividend : dividend;
			dvs_q <= divisor[DATA_WIDTH-1] ? -divisor : divisor;
			neg_q <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
		end else if (busy_q) begin
			if (!trial[DATA_WIDTH]) begin
				rem_q <= trial[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;
endmodule

// ===== src/smstep_dp.sv =====
// datapath: stack memory, depth, pc, halt flag, alu and result register
// depends on smstep_pkg and smstep_div
`timescale 1ns / 1ps

module smstep_dp #(
	parameter int STACK_DEPTH   = 128,
	parameter int PROGRAM_DEPTH = 128,
	parameter int DATA_WIDTH    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smstep_pkg::dp_cmd_t               cmd,
	output smstep_pkg::dp_stat_t              stat,
	input  logic [smstep_pkg::PcWidth-1:0]    program_length,
	input  logic [smstep_pkg::OpWidth-1:0]    opcode,
	input  logic [smstep_pkg::OperandWidth-1:0] operand,
	output logic [smstep_pkg::TrapWidth-1:0]  trap,
	output logic [smstep_pkg::PcWidth-1:0]    next_pc,
	output logic                              halted,
	output logic [smstep_pkg::DepthWidth-1:0] stack_depth,
	output logic [smstep_pkg::TopWidth-1:0]   top_value
);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int PW  = $clog2(PROGRAM_DEPTH);
	localparam int OW  = smstep_pkg::OperandWidth;
	localparam int TW  = smstep_pkg::TopWidth;
	localparam int TRW = smstep_pkg::TrapWidth;

	logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] top_rd_q, sec_rd_q, cache_q;
	logic [DW-1:0] depth_q;
	logic [PW-1:0] pc_q;
	logic          halt_q;
	logic [smstep_pkg::OpWidth-1:0] op_s1;
	logic [OW-1:0] opd_s1;
	logic          pc_bad_s1;

	logic [AW-1:0] top_addr, sec_addr;
	assign top_addr = AW'(depth_q - 1'b1);
	assign sec_addr = AW'(depth_q - 2'd2);

	// on load: read top and second, latch instruction and pc check
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			top_rd_q  <= mem[top_addr];
			sec_rd_q  <= mem[sec_addr];
			op_s1     <= opcode;
			opd_s1    <= operand;
			pc_bad_s1 <= {{(32-PW){1'b0}}, pc_q} >= {25'd0, program_length};
		end
	end

	logic [DATA_WIDTH-1:0] top_v, sec_v, push_v, alu_r;
	logic [2*DATA_WIDTH-1:0] prod;
	logic                  tgt_ok, has1, has2, full, wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [TRW-1:0]        trap_c;
	logic [DW-1:0]         depth_n;
	logic [PW-1:0]         pc_n;
	logic                  halt_n;
	logic [DATA_WIDTH-1:0] div_q;
	logic                  div_done;

	assign top_v  = top_rd_q;
	assign sec_v  = sec_rd_q;
	assign push_v = DATA_WIDTH'($signed(opd_s1));
	assign has1   = depth_q >= DW'(1);
	assign has2   = depth_q >= DW'(2);
	assign full   = depth_q >= DW'(STACK_DEPTH);
	assign tgt_ok = !opd_s1[OW-1] && (opd_s1 < OW'(PROGRAM_DEPTH));
	assign prod   = sec_v * top_v;

	// alu
	always_comb begin
		case (op_s1)
			smstep_pkg::OP_ADD: alu_r = sec_v + top_v;
			smstep_pkg::OP_SUB: alu_r = sec_v - top_v;
			smstep_pkg::OP_MUL: alu_r = prod[DATA_WIDTH-1:0];
			smstep_pkg::OP_EQ:  alu_r = DATA_WIDTH'(top_v == sec_v);
			smstep_pkg::OP_GT:  alu_r = DATA_WIDTH'($signed(sec_v) < $signed(top_v));
			smstep_pkg::OP_LT:  alu_r = DATA_WIDTH'($signed(top_v) < $signed(sec_v));
			default:            alu_r = div_q;
		endcase
	end

	// instruction decode and next state
	always_comb begin
		trap_c  = smstep_pkg::TRAP_OK;
		depth_n = depth_q;
		pc_n    = pc_q;
		halt_n  = halt_q;
		wr_en   = 1'b0;
		wr_addr = sec_addr;
		wr_data = alu_r;
		if (pc_bad_s1) begin
			trap_c = smstep_pkg::TRAP_OVERFLOW;
		end else begin
			unique case (op_s1)
				smstep_pkg::OP_PUSH: begin
					if (full) trap_c = smstep_pkg::TRAP_OVERFLOW;
					else begin
						wr_en = 1'b1; wr_addr = AW'(depth_q); wr_data = push_v;
						depth_n = depth_q + 1'b1; pc_n = pc_q + 1'b1;
					end
				end
				smstep_pkg::OP_POP: begin
					if (!has1) trap_c = smstep_pkg::TRAP_UNDERFLOW;
					else begin depth_n = depth_q - 1'b1; pc_n = pc_q + 1'b1; end
				end
				smstep_pkg::OP_HALT: halt_n = 1'b1;
				smstep_pkg::OP_JMP: begin
					if (!tgt_ok) trap_c = smstep_pkg::TRAP_BAD_ADDR;
					else pc_n = PW'(opd_s1);
				end
				smstep_pkg::OP_JMPIF: begin
					if (!has1) trap_c = smstep_pkg::TRAP_UNDERFLOW;
					else if (top_v != '0) begin
						if (!tgt_ok) trap_c = smstep_pkg::TRAP_BAD_ADDR;
						else begin depth_n = depth_q - 1'b1; pc_n = PW'(opd_s1); end
					end else pc_n = pc_q + 1'b1;
				end
				smstep_pkg::OP_ADD, smstep_pkg::OP_SUB, smstep_pkg::OP_DIV,
				smstep_pkg::OP_MUL, smstep_pkg::OP_EQ, smstep_pkg::OP_GT,
				smstep_pkg::OP_LT: begin
					if (!has2) trap_c = smstep_pkg::TRAP_UNDERFLOW;
					else if (op_s1 == smstep_pkg::OP_DIV && top_v == '0)
						trap_c = smstep_pkg::TRAP_DIV_ZERO;
					else begin
						wr_en = 1'b1; depth_n = depth_q - 1'b1; pc_n = pc_q + 1'b1;
					end
				end
				default: trap_c = smstep_pkg::TRAP_BAD_OP;
			endcase
		end
	end

	assign stat.div_needed = !pc_bad_s1 && op_s1 == smstep_pkg::OP_DIV && has2
		&& top_v != '0;
	assign stat.div_done   = div_done;

	smstep_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sec_v), .divisor(top_v), .done(div_done), .quotient(div_q)
	);

	logic commit;
	assign commit = cmd.exec || cmd.div_commit;

	// stack write
	always_ff @(posedge clk) begin
		if (commit && wr_en) mem[wr_addr] <= wr_data;
	end

	// architectural state: depth, program counter and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
		end else if (commit) begin
			depth_q <= depth_n;
			pc_q    <= pc_n;
			halt_q  <= halt_n;
		end
	end

	// trap and new top: written, second if one removed, else the old top
	always_ff @(posedge clk) begin
		if (commit) begin
			trap <= trap_c;
			if (trap_c != smstep_pkg::TRAP_OK) cache_q <= has1 ? top_v : '0;
			else if (wr_en) cache_q <= wr_data;
			else if (depth_n == depth_q) cache_q <= has1 ? top_v : '0;
			else cache_q <= (depth_n != '0) ? sec_v : '0;
		end
	end

	assign next_pc     = smstep_pkg::PcWidth'(pc_q);
	assign halted      = halt_q;
	assign stack_depth = smstep_pkg::DepthWidth'(depth_q);
	assign top_value   = TW'(cache_q);

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH)) else $error("depth beyond stack");
	a_trap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		commit && trap_c != smstep_pkg::TRAP_OK |=> $stable(depth_q) && $stable(pc_q))
		else $error("trap changed state");
	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (depth_q == $past(depth_q)) || (depth_q == $past(depth_q) + 1'b1)
		|| (depth_q == $past(depth_q) - 1'b1)) else $error("depth jumped");
endmodule

// ===== src/smstep_ctrl.sv =====
// controller: handshake and sequencing of load, execute and divide
// depends on smstep_pkg
`timescale 1ns / 1ps

module smstep_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output smstep_pkg::dp_cmd_t  cmd,
	input  smstep_pkg::dp_stat_t stat
);
	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;
	state_t state_q;
	logic   ovalid_q, dstart_q;

	// next item accepted in idle once the last result is taken or leaving
	assign in_ready = state_q == S_IDLE && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd.load       = in_valid && in_ready;
		cmd.exec       = state_q == S_EXEC && !stat.div_needed;
		cmd.div_start  = state_q == S_EXEC && stat.div_needed;
		cmd.div_commit = state_q == S_DIV && stat.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= cmd.div_start;
			if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_EXEC;
				S_EXEC: begin
					if (stat.div_needed) state_q <= S_DIV;
					else begin state_q <= S_IDLE; ovalid_q <= 1'b1; end
				end
				S_DIV: if (stat.div_done) begin state_q <= S_IDLE; ovalid_q <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.exec, cmd.div_start, cmd.div_commit}) <= 1)
		else $error("overlapping commands");
	a_div_after: assert property (@(posedge clk) disable iff (!arst_n)
		dstart_q |-> state_q == S_DIV) else $error("divide not tracked");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.load) else $error("load while busy");
endmodule

// ===== dv/smstep_tb_pkg.sv =====
// transaction types for the stack machine core testbench
// depends on smstep_pkg
`timescale 1ns / 1ps

package smstep_tb_pkg;
	import smstep_pkg::*;

	typedef struct packed {
		opcode_t                 opcode;
		logic [OperandWidth-1:0] operand;
	} instr_t;

	typedef struct packed {
		logic [TrapWidth-1:0]  trap;
		logic [PcWidth-1:0]    next_pc;
		logic                  halted;
		logic [DepthWidth-1:0] stack_depth;
		logic [TopWidth-1:0]   top_value;
	} result_t;
endpackage

// ===== dv/stack_checker.sv =====
// predicts each instruction's result and compares it with the core's output
// depends on smstep_pkg, smstep_tb_pkg
`timescale 1ns / 1ps

module stack_checker
	import smstep_pkg::*;
	import smstep_tb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	input  logic    instr_ready,
	input  instr_t  instr_payload,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result_payload,
	input  logic    cfg_we,
	input  logic [PcWidth-1:0] cfg_data,
	output int      fail_count,
	output int      pending
);
	localparam int StackSize = DefStackDepth;
	localparam int ProgSize  = DefProgramDepth;

	logic [31:0]           stack_mem [StackSize];
	logic [DepthWidth-1:0] depth;
	logic [PcWidth-1:0]    pc;
	logic                  halt_flag;
	logic [PcWidth-1:0]    prog_len;
	result_t               expected_q[$];

	assign pending = expected_q.size();

	// execute one instruction against the shadow machine
	task automatic execute(input instr_t it, output result_t r);
		logic [31:0] opnd, sec, tos, ans;
		logic        target_ok;
		trap_t       trap;
		opnd      = it.operand;
		target_ok = !opnd[31] && opnd < ProgSize;
		trap      = TRAP_OK;
		ans       = '0;
		if (pc >= prog_len) begin
			trap = TRAP_OVERFLOW;
		end else begin
			case (it.opcode)
				OP_PUSH: begin
					if (depth >= StackSize) trap = TRAP_OVERFLOW;
					else begin
						stack_mem[depth] = opnd;
						depth = depth + 1;
						pc = pc + 1;
					end
				end
				OP_POP: begin
					if (depth == 0) trap = TRAP_UNDERFLOW;
					else begin
						depth = depth - 1;
						pc = pc + 1;
					end
				end
				OP_HALT: halt_flag = 1'b1;
				OP_JMP: begin
					if (!target_ok) trap = TRAP_BAD_ADDR;
					else pc = opnd[PcWidth-1:0];
				end
				OP_JMPIF: begin
					if (depth < 1) trap = TRAP_UNDERFLOW;
					else if (stack_mem[depth-1] != 0) begin
						if (!target_ok) trap = TRAP_BAD_ADDR;
						else begin
							depth = depth - 1;
							pc = opnd[PcWidth-1:0];
						end
					end else pc = pc + 1;
				end
				OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_EQ, OP_GT, OP_LT: begin
					if (depth < 2) trap = TRAP_UNDERFLOW;
					else begin
						sec = stack_mem[depth-2];
						tos = stack_mem[depth-1];
						case (it.opcode)
							OP_ADD: ans = sec + tos;
							OP_SUB: ans = sec - tos;
							OP_MUL: ans = sec * tos;
							OP_DIV: begin
								if (tos == 0) trap = TRAP_DIV_ZERO;
								// minimum over minus one wraps to itself
								else if (sec == 32'h8000_0000 && tos == '1) ans = sec;
								else ans = $signed(sec) / $signed(tos);
							end
							OP_EQ: ans = {31'd0, tos == sec};
							OP_GT: ans = {31'd0, $signed(sec) < $signed(tos)};
							default: ans = {31'd0, $signed(tos) < $signed(sec)};
						endcase
						if (trap == TRAP_OK) begin
							stack_mem[depth-2] = ans;
							depth = depth - 1;
							pc = pc + 1;
						end
					end
				end
				default: trap = TRAP_BAD_OP;
			endcase
		end
		r.trap        = trap;
		r.next_pc     = pc;
		r.halted      = halt_flag;
		r.stack_depth = depth;
		r.top_value   = (depth > 0) ? stack_mem[depth-1] : '0;
	endtask

	// compare finished results, then predict newly accepted instructions
	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			depth      = '0;
			pc         = '0;
			halt_flag  = 1'b0;
			prog_len   = '0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				got = result_payload;
				if (expected_q.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("%t unexpected result transaction %p", $realtime, got);
				end else begin
					want = expected_q.pop_front();
					if (got.trap !== want.trap || got.next_pc !== want.next_pc ||
					    got.halted !== want.halted ||
					    got.stack_depth !== want.stack_depth ||
					    got.top_value !== want.top_value) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("%t result mismatch: expected %p, got %p",
								$realtime, want, got);
					end
				end
			end
			if (instr_valid && instr_ready) begin
				execute(instr_payload, want);
				expected_q.push_back(want);
			end
			if (cfg_we) prog_len = cfg_data;
		end
	end
endmodule

// ===== dv/testbench.sv =====
// top of the stack machine core testbench: clock, reset, instruction
// stimulus, result back-pressure and verdict; depends on smstep_pkg,
// smstep_tb_pkg, smstep_if, stack_checker and stack_machine_step
`timescale 1ns / 1ps

module testbench;
	import smstep_pkg::*;
	import smstep_tb_pkg::*;

	localparam int IdleLimit = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [PcWidth-1:0] cfg_data = '0;
	logic idle_en = 1'b1;
	int   stall_left = 0;
	int   fail_count, pending, quiet_cycles = 0;
	logic [PcWidth-1:0] last_pc = '0;
	int   prog_len = 0;

	smstep_if #(.payload_t(instr_t))  instr_ch ();
	smstep_if #(.payload_t(result_t)) result_ch ();

	initial begin
		instr_ch.valid   = 1'b0;
		instr_ch.payload = '0;
		result_ch.ready  = 1'b1;
	end

	always #10 clk = ~clk;

	stack_machine_step u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.result  (result_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	stack_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.instr_valid   (instr_ch.valid),
		.instr_ready   (instr_ch.ready),
		.instr_payload (instr_ch.payload),
		.result_valid  (result_ch.valid),
		.result_ready  (result_ch.ready),
		.result_payload(result_ch.payload),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// result back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else result_ch.ready <= 1'b1;
	end

	// program counter as seen by the fetcher, and the watchdog
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) last_pc <= result_ch.payload.next_pc;
		if (!arst_n || (instr_ch.valid && instr_ch.ready) ||
		    (result_ch.valid && result_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one instruction transaction, with an optional random gap before it
	task automatic issue(input opcode_t op, input logic [31:0] opnd);
		int gap;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			instr_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_ch.valid   <= 1'b1;
		instr_ch.payload <= '{opcode: op, operand: opnd};
		do @(posedge clk); while (!(instr_ch.valid && instr_ch.ready));
		@(negedge clk);
	endtask

	task automatic go_quiet();
		instr_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_length(input int len);
		go_quiet();
		cfg_we   <= 1'b1;
		cfg_data <= len[PcWidth-1:0];
		@(negedge clk);
		cfg_we   <= 1'b0;
		prog_len = len;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			4, 5: return $urandom_range(0, 9);
			6: return -$urandom_range(1, 9);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_target();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000 | $urandom;
			1: return $urandom_range(128, 300);
			default: return $urandom_range(0, prog_len - 8);
		endcase
	endfunction

	// random instruction, with a jump back whenever the end is near
	task automatic random_item();
		int      pick;
		opcode_t op;
		if (last_pc + 4 >= prog_len) begin
			issue(OP_JMP, $urandom_range(0, prog_len - 8));
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 32)      op = OP_PUSH;
		else if (pick < 40) op = OP_POP;
		else if (pick < 46) op = OP_ADD;
		else if (pick < 52) op = OP_SUB;
		else if (pick < 58) op = OP_MUL;
		else if (pick < 66) op = OP_DIV;
		else if (pick < 71) op = OP_EQ;
		else if (pick < 76) op = OP_GT;
		else if (pick < 81) op = OP_LT;
		else if (pick < 85) op = OP_JMP;
		else if (pick < 92) op = OP_JMPIF;
		else if (pick < 94) op = OP_HALT;
		else                op = opcode_t'($urandom_range(12, 15));
		if (op == OP_JMP || op == OP_JMPIF) issue(op, pick_target());
		else issue(op, pick_value());
	endtask

	task automatic random_phase(input int count, input bit deep);
		int n;
		for (n = 0; n < count; n++) begin
			// deep stack: fill past the top to reach overflow
			if (deep && n == 10) begin
				repeat (140) begin
					if (last_pc + 4 >= prog_len) issue(OP_JMP, 0);
					else issue(OP_PUSH, $urandom);
				end
			end
			if (n == count / 2) go_quiet();
			random_item();
		end
		issue(OP_JMP, 0);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty program: every step traps
		issue(OP_PUSH, 5);
		issue(OP_HALT, 0);

		// directed corner cases
		set_length(127);
		issue(OP_POP, 0);
		issue(OP_ADD, 0);
		issue(OP_JMPIF, 3);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_PUSH, 32'hffff_ffff);
		issue(OP_DIV, 0);
		issue(OP_PUSH, 0);
		issue(OP_DIV, 0);
		issue(OP_JMPIF, 32'hffff_ffff);
		issue(OP_PUSH, 32'h7fff_ffff);
		issue(OP_PUSH, 32'h7fff_ffff);
		issue(OP_MUL, 0);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_SUB, 0);
		issue(OP_PUSH, 7);
		issue(OP_EQ, 0);
		issue(OP_PUSH, 3);
		issue(OP_GT, 0);
		issue(OP_PUSH, 3);
		issue(OP_LT, 0);
		issue(OP_JMPIF, 200);
		issue(OP_JMP, 32'h8000_0000);
		issue(OP_JMP, 2);
		issue(opcode_t'(4'd15), 0);
		issue(OP_HALT, 0);
		issue(OP_JMP, 1);
		issue(OP_JMPIF, 0);

		random_phase(90, 1'b1);
		set_length(37);
		random_phase(70, 1'b0);
		set_length(127);
		idle_en = 1'b0;
		random_phase(80, 1'b0);

		// highest legal target leaves the counter at the program end
		issue(OP_JMP, 127);
		issue(OP_PUSH, 1);

		go_quiet();
		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
